>>> hdl/dect_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dect_pkg: shared types and constants for the event counter table
// Key layout, result status codes, write-enable group and saturating bump.
// ----------------------------------------------------------------------------
package dect_pkg;

  localparam int unsigned CNT_W  = 64;
  localparam int unsigned SLOT_W = 6;

  // Result status codes
  localparam logic [1:0] STATUS_MATCHED  = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;
  localparam logic [1:0] STATUS_CLEARED  = 2'd3;

  // Operation codes of the kind field
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic        executed;
    logic [4:0]  miss_code;
    logic        transfer;
    logic [31:0] call_address;
    logic [31:0] dest_address;
    logic [63:0] pack_gen;
    logic [63:0] run_gen;
  } key_t;

  typedef struct packed {
    logic key_we;
    logic cnt_we;
  } wr_en_t;

  // Increment, holding at all-ones
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (&v) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

>>> hdl/dect_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dect_mem: key and occurrence-count storage
// Two synchronous arrays sharing one read address, with registered read data.
// ----------------------------------------------------------------------------
module dect_mem #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned AW      = 6
) (
  input  logic                       clk,
  input  logic [AW-1:0]              rd_addr,
  output dect_pkg::key_t             rd_key,
  output logic [dect_pkg::CNT_W-1:0] rd_count,
  input  dect_pkg::wr_en_t           wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  dect_pkg::key_t             wr_key,
  input  logic [dect_pkg::CNT_W-1:0] wr_count
);

  dect_pkg::key_t             key_mem [ENTRIES];
  logic [dect_pkg::CNT_W-1:0] cnt_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en.cnt_we) begin
      cnt_mem[wr_addr] <= wr_count;
    end
    rd_count <= cnt_mem[rd_addr];
  end

endmodule

>>> hdl/dedup_event_counter_table_unit.sv
`timescale 1ns / 1ps
// A record beat searches the filled entries in slot order and exits early on a match, then
//   reports a match, an insert or a drop; a clear goes straight to its result.
// A new item is taken only once the previous result has moved into the output register; the
//   linear key search reads one stored key per cycle from the key memory's single read port.
// Reset: synchronous, active low; empties the table and zeroes both totals.
//   Memory contents are not cleared: only slots below the fill count are read.
// ----------------------------------------------------------------------------
// dedup_event_counter_table_unit: deduplicating event counter table
// Counts event keys in an associative table with saturating counters.
// ----------------------------------------------------------------------------
module dedup_event_counter_table_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic        in_executed,
  input  logic [4:0]  in_miss_code,
  input  logic        in_transfer,
  input  logic [31:0] in_call_address,
  input  logic [31:0] in_dest_address,
  input  logic [63:0] in_pack_gen,
  input  logic [63:0] in_run_gen,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [63:0] out_entry_count,
  output logic [63:0] out_total_count,
  output logic [63:0] out_dropped_count
);

  // Address width for the memories, count width able to hold ENTRIES itself
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned W  = dect_pkg::CNT_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  // Control state
  logic [1:0]    state_r,         state_nxt;
  logic [CW-1:0] used_r,          used_nxt;
  logic [W-1:0]  total_seen_r,    total_seen_nxt;
  logic [W-1:0]  total_dropped_r, total_dropped_nxt;
  logic [CW-1:0] issue_r,         issue_nxt;
  logic          cmp_valid_r,     cmp_valid_nxt;
  logic [CW-1:0] cmp_idx_r,       cmp_idx_nxt;
  logic          out_valid_r,     out_valid_nxt;

  // Payload (no reset)
  dect_pkg::key_t   key_r,        key_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [5:0]       res_slot_r,   res_slot_nxt;
  logic [W-1:0]     res_count_r,  res_count_nxt;
  logic [1:0]       out_status_r;
  logic [5:0]       out_slot_r;
  logic [W-1:0]     out_entry_r;
  logic [W-1:0]     out_total_r;
  logic [W-1:0]     out_dropped_r;

  // Memory interface
  logic [AW-1:0]     rd_addr;
  dect_pkg::key_t    rd_key;
  logic [W-1:0]      rd_count;
  dect_pkg::wr_en_t  wr_en;
  logic [AW-1:0]     wr_addr;
  logic [W-1:0]      wr_count;

  logic in_fire;
  logic out_load;
  logic hit;
  logic search_end;
  logic full;

  dect_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_count (rd_count),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_count (wr_count)
  );

  // Take a new beat only between searches; a pending result sits in the
  // output register and does not block the next acceptance.
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Drain the finished result into the output register once it is free
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // The read issued last cycle returns now; compare it to the held key
  assign hit        = cmp_valid_r && (rd_key == key_r);
  // Search is over when the last filled slot has been compared, or none exist
  assign search_end = (used_r == '0) ||
                      (cmp_valid_r && (CW'(cmp_idx_r + 1'b1) == used_r));
  assign full       = (used_r == CW'(ENTRIES));

  // Issue reads in slot order, one per cycle
  assign rd_addr = issue_r[AW-1:0];

  always_comb begin
    state_nxt         = state_r;
    used_nxt          = used_r;
    total_seen_nxt    = total_seen_r;
    total_dropped_nxt = total_dropped_r;
    issue_nxt         = issue_r;
    cmp_valid_nxt     = 1'b0;
    cmp_idx_nxt       = cmp_idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    key_nxt           = key_r;
    res_status_nxt    = res_status_r;
    res_slot_nxt      = res_slot_r;
    res_count_nxt     = res_count_r;
    wr_en             = '0;
    wr_addr           = cmp_idx_r[AW-1:0];
    wr_count          = dect_pkg::sat_inc(rd_count);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt.executed     = in_executed;
          key_nxt.miss_code    = in_miss_code;
          key_nxt.transfer     = in_transfer;
          key_nxt.call_address = in_call_address;
          key_nxt.dest_address = in_dest_address;
          key_nxt.pack_gen     = in_pack_gen;
          key_nxt.run_gen      = in_run_gen;
          if (in_kind == dect_pkg::KIND_CLEAR) begin
            // Drop all entries and zero both totals
            used_nxt          = '0;
            total_seen_nxt    = '0;
            total_dropped_nxt = '0;
            res_status_nxt    = dect_pkg::STATUS_CLEARED;
            res_slot_nxt      = '0;
            res_count_nxt     = '0;
            state_nxt         = ST_DONE;
          end else begin
            // Count the event up front, whatever the outcome
            total_seen_nxt = dect_pkg::sat_inc(total_seen_r);
            issue_nxt      = '0;
            state_nxt      = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          // Bump the matched entry's count in place
          wr_en.cnt_we   = 1'b1;
          wr_addr        = cmp_idx_r[AW-1:0];
          wr_count       = dect_pkg::sat_inc(rd_count);
          res_status_nxt = dect_pkg::STATUS_MATCHED;
          res_slot_nxt   = 6'({6'b0, cmp_idx_r});
          res_count_nxt  = dect_pkg::sat_inc(rd_count);
          state_nxt      = ST_DONE;
        end else if (search_end) begin
          if (full) begin
            total_dropped_nxt = dect_pkg::sat_inc(total_dropped_r);
            res_status_nxt    = dect_pkg::STATUS_DROPPED;
            res_slot_nxt      = '0;
            res_count_nxt     = '0;
          end else begin
            // Append the key at the next free slot with a count of one
            wr_en.key_we   = 1'b1;
            wr_en.cnt_we   = 1'b1;
            wr_addr        = used_r[AW-1:0];
            wr_count       = W'(1);
            used_nxt       = CW'(used_r + 1'b1);
            res_status_nxt = dect_pkg::STATUS_INSERTED;
            res_slot_nxt   = 6'({6'b0, used_r});
            res_count_nxt  = W'(1);
          end
          state_nxt = ST_DONE;
        end else if (issue_r < used_r) begin
          // Advance the read pointer; tag the returning data with its slot
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = issue_r;
          issue_nxt     = CW'(issue_r + 1'b1);
        end
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      used_r          <= '0;
      total_seen_r    <= '0;
      total_dropped_r <= '0;
      issue_r         <= '0;
      cmp_valid_r     <= 1'b0;
      cmp_idx_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      used_r          <= used_nxt;
      total_seen_r    <= total_seen_nxt;
      total_dropped_r <= total_dropped_nxt;
      issue_r         <= issue_nxt;
      cmp_valid_r     <= cmp_valid_nxt;
      cmp_idx_r       <= cmp_idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers; hold the output beat until it is taken
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_count_r  <= res_count_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_slot_r    <= res_slot_r;
      out_entry_r   <= res_count_r;
      out_total_r   <= total_seen_r;
      out_dropped_r <= total_dropped_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_entry_count   = out_entry_r;
  assign out_total_count   = out_total_r;
  assign out_dropped_count = out_dropped_r;

endmodule

>>> hdl/dect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dect_checker: port-level checks for the event counter table
// Watches the result channel for consistent status and counter values.
// ----------------------------------------------------------------------------
module dect_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [5:0]  out_slot,
  input logic [63:0] out_entry_count,
  input logic [63:0] out_total_count,
  input logic [63:0] out_dropped_count
);

  // A stalled result beat holds its status, slot, entry count and total count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot) && $stable(out_entry_count) && $stable(out_total_count))
    else $error("result beat changed while stalled");

  // A dropped event touches no entry but is still counted in both totals
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dect_pkg::STATUS_DROPPED) |->
      (out_slot == '0) && (out_entry_count == '0) &&
      (out_total_count != '0) && (out_dropped_count != '0))
    else $error("dropped beat carries inconsistent fields");

  // A clear reports all zeros
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dect_pkg::STATUS_CLEARED) |->
      (out_slot == '0) && (out_entry_count == '0) &&
      (out_total_count == '0) && (out_dropped_count == '0))
    else $error("clear beat carries nonzero fields");

  // A new entry starts at one; a match always sees at least two
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dect_pkg::STATUS_INSERTED) |->
      (out_entry_count == 64'd1) && (out_total_count != '0))
    else $error("inserted entry count is not one");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dect_pkg::STATUS_MATCHED) |->
      (out_entry_count > 64'd1) && (out_total_count > 64'd1))
    else $error("matched entry count too small");

endmodule

bind dedup_event_counter_table_unit dect_checker u_dect_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_slot          (out_slot),
  .out_entry_count   (out_entry_count),
  .out_total_count   (out_total_count),
  .out_dropped_count (out_dropped_count)
);
